// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define IRT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition is followed by another one in the next cycle
`define IRT_ASSERT_NEXT(name, cond, nxt, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

// File: rtl/irt_pkg.sv
package irt_pkg;

   localparam int DEF_MAX_BUFFER_BYTES = 65536;

   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_RBR  = 8'h5D;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;

   localparam logic [2:0] KIND_KEY_VALUE = 3'd0;
   localparam logic [2:0] KIND_SECTION   = 3'd1;
   localparam logic [2:0] KIND_FINISHED  = 3'd2;
   localparam logic [2:0] KIND_NO_VALUE  = 3'd3;
   localparam logic [2:0] KIND_UNTERM    = 3'd4;

   typedef struct packed {
      logic space;
      logic line_end;
      logic eq;
      logic lbr;
      logic rbr;
      logic hash;
      logic nul;
   } class_type;

   typedef struct packed {
      class_type cls;
      logic      first_of_buffer;
      logic      last_of_buffer;
   } item_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [15:0] name_start;
      logic [16:0] name_length;
      logic [15:0] value_start;
      logic [16:0] value_length;
      logic [16:0] consumed_total;
      logic        done_res;
   } result_type;

   function automatic class_type classify(input logic [7:0] b);
      class_type c;
      c.space    = (b == CH_SP) || (b inside {[CH_TAB:CH_CR]});
      c.line_end = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
      c.eq       = (b == CH_EQ);
      c.lbr      = (b == CH_LBR);
      c.rbr      = (b == CH_RBR);
      c.hash     = (b == CH_HASH);
      c.nul      = (b == CH_NUL);
      return c;
   endfunction

endpackage

// File: rtl/irt_queue.sv
`include "assert_macros.svh"

module irt_queue
   import irt_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign dout    = head_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (do_push && do_pop) begin
         if (count_ff == 2'd1) begin
            head_in = din;
         end else begin
            head_in = tail_ff;
            tail_in = din;
         end
      end else if (do_pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (do_push) begin
         if (count_ff == 2'd0) begin
            head_in = din;
         end else begin
            tail_in = din;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `IRT_ASSERT(a_count_range, count_ff != 2'd3, "queue count out of range")
   `IRT_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(dout), "queue head moved")

endmodule

// File: rtl/irt_front.sv
module irt_front
   import irt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_buffer,
   input  logic       req_last_of_buffer,
   input  logic       item_pop,
   output item_type   item,
   output logic       item_empty
);

   item_type          item_new;
   logic [$bits(item_type)-1:0] item_bits;

   always_comb begin
      item_new.cls             = classify(req_data_byte);
      item_new.first_of_buffer = req_first_of_buffer;
      item_new.last_of_buffer  = req_last_of_buffer;
   end

   irt_queue #(
      .WIDTH($bits(item_type))
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .din  (item_new),
      .full (req_full),
      .pop  (item_pop),
      .dout (item_bits),
      .empty(item_empty)
   );

   assign item = item_type'(item_bits);

endmodule

// File: rtl/irt_scan.sv
`include "assert_macros.svh"

module irt_scan
   import irt_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_empty,
   input  item_type   in_item,
   output logic       in_pop,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_res
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
   localparam int LEN_W = $clog2(MAX_BUFFER_BYTES + 1);

   localparam logic [2:0] PH_STOPPED = 3'd0;
   localparam logic [2:0] PH_IDLE    = 3'd1;
   localparam logic [2:0] PH_COMMENT = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_SECTION = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] tstart_ff, tstart_in;
   logic [LEN_W-1:0] tlen_ff, tlen_in;
   logic [LEN_W-1:0] vstart_ff, vstart_in;
   logic [LEN_W-1:0] vlen_ff, vlen_in;
   logic [LEN_W-1:0] total_ff, total_in;

   logic             take, again, last, have, done;
   logic [2:0]       kind;
   logic [POS_W-1:0] ns;
   logic [LEN_W-1:0] nl, vs, vl, p1;
   class_type        c;

   assign take   = !in_empty && !out_full;
   assign in_pop = take;
   assign c      = in_item.cls;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      vstart_in = vstart_ff;
      vlen_in   = vlen_ff;
      total_in  = total_ff;
      have      = 1'b0;
      done      = 1'b0;
      again     = 1'b0;
      kind      = KIND_KEY_VALUE;
      ns        = '0;
      nl        = '0;
      vs        = '0;
      vl        = '0;
      if (in_item.first_of_buffer) begin
         phase_in  = PH_IDLE;
         pos_in    = '0;
         tstart_in = '0;
         tlen_in   = '0;
         vstart_in = '0;
         vlen_in   = '0;
         total_in  = '0;
      end
      last = in_item.last_of_buffer || (pos_in == POS_W'(MAX_BUFFER_BYTES - 1));
      p1   = LEN_W'(pos_in) + LEN_W'(1);
      if (phase_in != PH_STOPPED) begin
         case (phase_in)
            PH_IDLE: begin
               again = 1'b1;
            end
            PH_COMMENT: begin
               if (c.line_end) begin
                  phase_in = PH_IDLE;
                  again    = 1'b1;
               end
            end
            PH_KEY: begin
               if (c.eq) begin
                  phase_in  = PH_VALUE;
                  vstart_in = p1;
                  vlen_in   = '0;
               end else if (c.line_end) begin
                  have     = 1'b1;
                  kind     = KIND_NO_VALUE;
                  ns       = tstart_in;
                  nl       = tlen_in;
                  done     = 1'b1;
                  phase_in = PH_STOPPED;
               end else begin
                  tlen_in = tlen_in + LEN_W'(1);
               end
            end
            PH_VALUE: begin
               if (c.line_end || c.eq) begin
                  total_in = LEN_W'(pos_in);
                  if (tlen_in != '0) begin
                     have = 1'b1;
                     kind = KIND_KEY_VALUE;
                     ns   = tstart_in;
                     nl   = tlen_in;
                     vs   = vstart_in;
                     vl   = vlen_in;
                  end
                  phase_in = PH_IDLE;
                  again    = 1'b1;
               end else begin
                  vlen_in = vlen_in + LEN_W'(1);
               end
            end
            PH_SECTION: begin
               if (c.rbr) begin
                  tlen_in  = tlen_in + LEN_W'(1);
                  total_in = p1;
                  have     = 1'b1;
                  kind     = KIND_SECTION;
                  ns       = tstart_in;
                  nl       = tlen_in;
                  phase_in = PH_IDLE;
               end else if (c.line_end) begin
                  have     = 1'b1;
                  kind     = KIND_UNTERM;
                  ns       = tstart_in;
                  nl       = tlen_in;
                  done     = 1'b1;
                  phase_in = PH_STOPPED;
               end else begin
                  tlen_in = tlen_in + LEN_W'(1);
               end
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase
         if (again) begin
            if (c.space) begin
               phase_in = PH_IDLE;
            end else if (c.hash) begin
               phase_in = PH_COMMENT;
            end else if (c.nul) begin
               if (!have) begin
                  have = 1'b1;
                  ns   = pos_in;
                  nl   = '0;
               end
               kind     = KIND_NO_VALUE;
               done     = 1'b1;
               phase_in = PH_STOPPED;
            end else begin
               tstart_in = pos_in;
               if (c.lbr) begin
                  phase_in = PH_SECTION;
                  tlen_in  = LEN_W'(1);
               end else if (c.eq) begin
                  phase_in  = PH_VALUE;
                  tlen_in   = '0;
                  vstart_in = p1;
                  vlen_in   = '0;
               end else begin
                  phase_in = PH_KEY;
                  tlen_in  = LEN_W'(1);
               end
            end
         end
         if (phase_in != PH_STOPPED && last) begin
            if (phase_in == PH_KEY) begin
               have = 1'b1;
               kind = KIND_NO_VALUE;
               ns   = tstart_in;
               nl   = tlen_in;
            end else if (phase_in == PH_SECTION) begin
               have = 1'b1;
               kind = KIND_UNTERM;
               ns   = tstart_in;
               nl   = tlen_in;
            end else begin
               if (phase_in == PH_VALUE) begin
                  total_in = p1;
                  if (tlen_in != '0) begin
                     have = 1'b1;
                     kind = KIND_KEY_VALUE;
                     ns   = tstart_in;
                     nl   = tlen_in;
                     vs   = vstart_in;
                     vl   = vlen_in;
                  end
               end
               if (!have) begin
                  have = 1'b1;
                  kind = KIND_FINISHED;
               end
            end
            done     = 1'b1;
            phase_in = PH_STOPPED;
         end
         if (phase_in != PH_STOPPED) begin
            pos_in = pos_in + POS_W'(1);
         end
      end
   end

   always_comb begin
      out_push               = take && have;
      out_res.record_kind    = kind;
      out_res.name_start     = 16'(ns);
      out_res.name_length    = 17'(nl);
      out_res.value_start    = 16'(vs);
      out_res.value_length   = 17'(vl);
      out_res.consumed_total = 17'(total_in);
      out_res.done_res       = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STOPPED;
         pos_ff    <= '0;
         tstart_ff <= '0;
         tlen_ff   <= '0;
         vstart_ff <= '0;
         vlen_ff   <= '0;
         total_ff  <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
         vstart_ff <= vstart_in;
         vlen_ff   <= vlen_in;
         total_ff  <= total_in;
      end
   end

   `IRT_ASSERT_NEXT(a_done_stops,
      out_push && out_res.done_res, phase_ff == PH_STOPPED,
      "scanner kept running after final word")
   `IRT_ASSERT(a_stopped_quiet,
      in_pop && !in_item.first_of_buffer && phase_ff == PH_STOPPED |-> !out_push,
      "word produced while stopped")

endmodule

// File: rtl/ini_record_tokenizer.sv
// INI record tokenizer: push one byte of an INI buffer per clock, marking the
// first byte of each buffer and its last byte; records (key/value, section,
// finished, or the first error) come out of the result queue in order, at most
// one per input byte, with done_res set on the word that ends the buffer.
// Sustained rate is one byte per clock when neither queue stalls: the scanner
// handles each byte as it pops it from the classify queue. A byte is
// registered in the classify queue and its record in the result queue before
// the record is visible. Bytes after a buffer ends are dropped until
// first_of_buffer is set, and the scanner starts stopped after reset.
module ini_record_tokenizer
   import irt_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_buffer,
   input  logic        req_last_of_buffer,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_record_kind,
   output logic [15:0] rsp_name_start,
   output logic [16:0] rsp_name_length,
   output logic [15:0] rsp_value_start,
   output logic [16:0] rsp_value_length,
   output logic [16:0] rsp_consumed_total,
   output logic        rsp_done_res
);

   item_type   item;
   logic       item_empty, item_pop;
   logic       res_full, res_push;
   result_type res_new;
   logic [$bits(result_type)-1:0] res_bits;
   result_type res_head;

   irt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_first_of_buffer(req_first_of_buffer),
      .req_last_of_buffer (req_last_of_buffer),
      .item_pop           (item_pop),
      .item               (item),
      .item_empty         (item_empty)
   );

   irt_scan #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .in_empty(item_empty),
      .in_item (item),
      .in_pop  (item_pop),
      .out_full(res_full),
      .out_push(res_push),
      .out_res (res_new)
   );

   irt_queue #(
      .WIDTH($bits(result_type))
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (res_push),
      .din  (res_new),
      .full (res_full),
      .pop  (rsp_pop),
      .dout (res_bits),
      .empty(rsp_empty)
   );

   assign res_head           = result_type'(res_bits);
   assign rsp_record_kind    = res_head.record_kind;
   assign rsp_name_start     = res_head.name_start;
   assign rsp_name_length    = res_head.name_length;
   assign rsp_value_start    = res_head.value_start;
   assign rsp_value_length   = res_head.value_length;
   assign rsp_consumed_total = res_head.consumed_total;
   assign rsp_done_res       = res_head.done_res;

endmodule

// File: tb/sv/ini_record_tokenizer_check.sv
`timescale 1ns / 100ps

module ini_record_tokenizer_check
   import irt_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_buffer,
   input  logic        req_last_of_buffer,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [2:0]  rsp_record_kind,
   input  logic [15:0] rsp_name_start,
   input  logic [16:0] rsp_name_length,
   input  logic [15:0] rsp_value_start,
   input  logic [16:0] rsp_value_length,
   input  logic [16:0] rsp_consumed_total,
   input  logic        rsp_done_res,
   output int          mismatch_count,
   output int          expected_count
);

   localparam logic [2:0] SCAN_STOPPED = 3'd0;
   localparam logic [2:0] SCAN_IDLE    = 3'd1;
   localparam logic [2:0] SCAN_COMMENT = 3'd2;
   localparam logic [2:0] SCAN_KEY     = 3'd3;
   localparam logic [2:0] SCAN_VALUE   = 3'd4;
   localparam logic [2:0] SCAN_SECTION = 3'd5;

   logic [2:0]  scan_state;
   int unsigned offset;
   int unsigned tok_start;
   int unsigned tok_len;
   int unsigned val_start;
   int unsigned val_len;
   int unsigned consumed;

   result_type  rec;
   bit          rec_valid;
   bit          rec_done;
   result_type  expected_records[$];
   int          failures;

   function automatic bit is_blank(logic [7:0] b);
      return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic bit ends_line(logic [7:0] b);
      return b == CH_NUL || b == CH_LF || b == CH_CR;
   endfunction

   function automatic string describe(result_type r);
      return $sformatf("kind %0d name %0d/%0d value %0d/%0d total %0d done %0b",
                       r.record_kind, r.name_start, r.name_length, r.value_start,
                       r.value_length, r.consumed_total, r.done_res);
   endfunction

   task automatic clear_scan();
      offset = 0;
      tok_start = 0;
      tok_len = 0;
      val_start = 0;
      val_len = 0;
      consumed = 0;
   endtask

   task automatic emit_record(logic [2:0] kind, int unsigned ns, int unsigned nl,
                              int unsigned vs, int unsigned vl);
      rec_valid = 1'b1;
      rec.record_kind = kind;
      rec.name_start = 16'(ns);
      rec.name_length = 17'(nl);
      rec.value_start = 16'(vs);
      rec.value_length = 17'(vl);
   endtask

   task automatic abort_scan(logic [2:0] kind, int unsigned ns, int unsigned nl);
      // a NUL that closes a value turns the finished pair into the error word
      if (rec_valid && rec.record_kind == KIND_KEY_VALUE)
         rec.record_kind = kind;
      else
         emit_record(kind, ns, nl, 0, 0);
      rec_done = 1'b1;
      scan_state = SCAN_STOPPED;
   endtask

   task automatic close_pair(int unsigned end_pos);
      consumed = end_pos;
      if (tok_len != 0)
         emit_record(KIND_KEY_VALUE, tok_start, tok_len, val_start, val_len);
   endtask

   task automatic scan_byte(logic [7:0] b, int unsigned p);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (scan_state)
            SCAN_IDLE: begin
               if (b == CH_HASH) begin
                  scan_state = SCAN_COMMENT;
               end else if (b == CH_NUL) begin
                  abort_scan(KIND_NO_VALUE, p, 0);
               end else if (!is_blank(b)) begin
                  tok_start = p;
                  if (b == CH_LBR) begin
                     scan_state = SCAN_SECTION;
                     tok_len = 1;
                  end else if (b == CH_EQ) begin
                     scan_state = SCAN_VALUE;
                     tok_len = 0;
                     val_start = p + 1;
                     val_len = 0;
                  end else begin
                     scan_state = SCAN_KEY;
                     tok_len = 1;
                  end
               end
            end
            SCAN_COMMENT: begin
               if (ends_line(b)) begin
                  scan_state = SCAN_IDLE;
                  again = 1'b1;
               end
            end
            SCAN_KEY: begin
               if (b == CH_EQ) begin
                  scan_state = SCAN_VALUE;
                  val_start = p + 1;
                  val_len = 0;
               end else if (ends_line(b)) begin
                  abort_scan(KIND_NO_VALUE, tok_start, tok_len);
               end else begin
                  tok_len++;
               end
            end
            SCAN_VALUE: begin
               if (ends_line(b) || b == CH_EQ) begin
                  close_pair(p);
                  scan_state = SCAN_IDLE;
                  again = 1'b1;
               end else begin
                  val_len++;
               end
            end
            SCAN_SECTION: begin
               if (b == CH_RBR) begin
                  tok_len++;
                  consumed = p + 1;
                  emit_record(KIND_SECTION, tok_start, tok_len, 0, 0);
                  scan_state = SCAN_IDLE;
               end else if (ends_line(b)) begin
                  abort_scan(KIND_UNTERM, tok_start, tok_len);
               end else begin
                  tok_len++;
               end
            end
            default: begin
               scan_state = SCAN_STOPPED;
            end
         endcase
      end
   endtask

   task automatic finish_buffer(int unsigned p);
      case (scan_state)
         SCAN_KEY: begin
            abort_scan(KIND_NO_VALUE, tok_start, tok_len);
            return;
         end
         SCAN_SECTION: begin
            abort_scan(KIND_UNTERM, tok_start, tok_len);
            return;
         end
         SCAN_VALUE: begin
            close_pair(p + 1);
         end
         default: begin
         end
      endcase
      if (!rec_valid)
         emit_record(KIND_FINISHED, 0, 0, 0, 0);
      rec_done = 1'b1;
      scan_state = SCAN_STOPPED;
   endtask

   task automatic tokenize_byte(logic [7:0] b, logic first, logic mark_last);
      int unsigned p;
      bit at_end;
      rec_valid = 1'b0;
      rec_done = 1'b0;
      rec = '0;
      if (first) begin
         scan_state = SCAN_IDLE;
         clear_scan();
      end
      if (scan_state == SCAN_STOPPED)
         return;
      p = offset;
      at_end = mark_last || (p + 1 >= MAX_BUFFER_BYTES);
      scan_byte(b, p);
      if (scan_state != SCAN_STOPPED && at_end)
         finish_buffer(p);
      if (scan_state != SCAN_STOPPED)
         offset = p + 1;
      if (rec_valid) begin
         rec.consumed_total = 17'(consumed);
         rec.done_res = rec_done;
         expected_records.push_back(rec);
      end
   endtask

   initial begin
      failures = 0;
      scan_state = SCAN_STOPPED;
      clear_scan();
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         scan_state = SCAN_STOPPED;
         clear_scan();
         expected_records.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.record_kind = rsp_record_kind;
            seen.name_start = rsp_name_start;
            seen.name_length = rsp_name_length;
            seen.value_start = rsp_value_start;
            seen.value_length = rsp_value_length;
            seen.consumed_total = rsp_consumed_total;
            seen.done_res = rsp_done_res;
            if (expected_records.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: record word with none pending: %s", $time, describe(seen));
            end else begin
               want = expected_records.pop_front();
               if (seen !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: record word differs\n   expected %s\n   actual   %s",
                              $time, describe(want), describe(seen));
               end
            end
         end
         if (req_push && !req_full)
            tokenize_byte(req_data_byte, req_first_of_buffer, req_last_of_buffer);
      end
      expected_count <= expected_records.size();
      mismatch_count <= failures;
   end

endmodule

// File: tb/sv/ini_record_tokenizer_test.sv
`timescale 1ns / 100ps

module ini_record_tokenizer_test;
   import irt_pkg::*;

   localparam int MAX_BYTES = DEF_MAX_BUFFER_BYTES;
   localparam int ITEMS = 1750;
   localparam int STALL_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_of_buffer = 1'b0;
   logic        req_last_of_buffer = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_record_kind;
   logic [15:0] rsp_name_start;
   logic [16:0] rsp_name_length;
   logic [15:0] rsp_value_start;
   logic [16:0] rsp_value_length;
   logic [16:0] rsp_consumed_total;
   logic        rsp_done_res;
   int          mismatch_count;
   int          expected_count;

   int          burst_left = 0;
   logic [15:0] pop_pattern = 16'h0001;
   int          pop_steps = 0;
   bit          pop_free = 1'b0;
   int          stalled_cycles;
   logic [7:0]  text_q[$];

   ini_record_tokenizer #(.MAX_BUFFER_BYTES(MAX_BYTES)) uut (.*);

   ini_record_tokenizer_check #(.MAX_BUFFER_BYTES(MAX_BYTES)) checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(negedge clock) begin
      if (pop_steps == 0) begin
         pop_pattern = 16'($urandom) | 16'h0001;
         pop_steps = $urandom_range(16, 96);
         pop_free = ($urandom_range(0, 3) == 0);
      end
      pop_steps--;
      pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
      rsp_pop = pop_free || pop_pattern[0];
   end

   initial begin
      stalled_cycles = 0;
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("ini_record_tokenizer: mismatch");
      $finish;
   end

   task automatic send_byte(logic [7:0] b, logic first, logic mark_last);
      if (burst_left <= 0) begin
         req_push = 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 32);
      end
      req_push = 1'b1;
      req_data_byte = b;
      req_first_of_buffer = first;
      req_last_of_buffer = mark_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_text(string s, bit mark_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == 0, mark_last && i == s.len() - 1);
   endtask

   task automatic add_plain(int n);
      repeat (n) begin
         if ($urandom_range(0, 15) == 0)
            text_q.push_back(8'($urandom_range(128, 255)));
         else
            text_q.push_back(8'($urandom_range(8'h30, 8'h39) + (($urandom_range(0, 2) != 0) ?
                                                                 8'h31 : 8'h0)));
      end
   endtask

   task automatic add_line_end(bit clean);
      case ($urandom_range(0, clean ? 18 : 19))
         0, 1, 2, 3, 4, 5, 6, 7: text_q.push_back(CH_LF);
         8, 9, 10, 11: text_q.push_back(CH_CR);
         12, 13, 14, 15: begin
            text_q.push_back(CH_CR);
            text_q.push_back(CH_LF);
         end
         16, 17, 18: begin
            text_q.push_back(CH_LF);
            text_q.push_back(CH_LF);
         end
         default: text_q.push_back(CH_NUL);
      endcase
   endtask

   task automatic add_record(bit clean);
      case ($urandom_range(0, clean ? 17 : 19))
         0, 1: text_q.push_back(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
         2, 3: begin
            text_q.push_back(CH_HASH);
            add_plain($urandom_range(0, 6));
            add_line_end(clean);
         end
         4, 5, 6: begin
            text_q.push_back(CH_LBR);
            add_plain($urandom_range(0, 6));
            text_q.push_back(CH_RBR);
            add_line_end(clean);
         end
         17: begin
            text_q.push_back(CH_EQ);
            add_plain($urandom_range(0, 4));
            add_line_end(clean);
         end
         18: begin
            if ($urandom_range(0, 1) != 0)
               text_q.push_back(CH_LBR);
            add_plain($urandom_range(1, 4));
            add_line_end(clean);
         end
         19: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
         default: begin
            add_plain($urandom_range(1, 6));
            text_q.push_back(CH_EQ);
            add_plain($urandom_range(0, 8));
            if ($urandom_range(0, 7) == 0)
               text_q.push_back(CH_EQ);
            add_line_end(clean);
         end
      endcase
   endtask

   initial begin
      int buffer_bytes;
      int target;
      bit mark_last;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_byte("x", 1'b0, 1'b0);
      send_text(" [s]\nk=v", 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte("z", 1'b0, 1'b0);
      send_byte(CH_EQ, 1'b1, 1'b0);
      send_byte(CH_NUL, 1'b0, 1'b0);
      send_text("a=", 1'b0);
      send_byte(CH_NUL, 1'b0, 1'b0);
      send_text("[x\n", 1'b0);
      send_text("#c", 1'b1);
      send_byte(CH_NUL, 1'b1, 1'b1);
      send_byte(CH_SP, 1'b1, 1'b1);
      send_text("[]", 1'b1);

      buffer_bytes = 0;
      while (buffer_bytes < ITEMS) begin
         text_q.delete();
         target = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
         while (text_q.size() < target)
            add_record(($urandom_range(0, 3) == 0));
         if ($urandom_range(0, 3) == 0) begin
            target = $urandom_range(1, text_q.size());
            while (text_q.size() > target)
               void'(text_q.pop_back());
         end
         mark_last = ($urandom_range(0, 19) != 0);
         foreach (text_q[i])
            send_byte(text_q[i], i == 0, mark_last && i == text_q.size() - 1);
         buffer_bytes += text_q.size();
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
      end

      req_push = 1'b0;
      while (expected_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ini_record_tokenizer: match");
      else
         $display("ini_record_tokenizer: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/irt_pkg.sv
rtl/irt_queue.sv
rtl/irt_front.sv
rtl/irt_scan.sv
rtl/ini_record_tokenizer.sv
tb/sv/ini_record_tokenizer_check.sv
tb/sv/ini_record_tokenizer_test.sv
